// File: rtl/cqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cqs_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SRCH = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // per-cell control from the queue controller
  typedef struct packed {
    logic shift;   // take the word of the neighbor toward the tail
    logic load;    // take the enqueued word
    logic active;  // cell holds a queued entry
  } cell_ctrl_t;

  // search probe handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] key;
  } probe_t;

  // search outcome reported by a cell
  typedef struct packed {
    logic hit;
    logic miss;
  } cell_stat_t;

endpackage

`default_nettype wire

// File: rtl/cqs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module cqs_cell (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire cqs_pkg::cell_ctrl_t              ctrl,
  input  wire logic signed [cqs_pkg::DATA_W-1:0] load_data,
  input  wire logic signed [cqs_pkg::DATA_W-1:0] right_data,
  input  wire cqs_pkg::probe_t                  probe_in,
  output logic signed [cqs_pkg::DATA_W-1:0]      data,
  output cqs_pkg::probe_t                       probe_out,
  output cqs_pkg::cell_stat_t                   stat
);

  logic signed [cqs_pkg::DATA_W-1:0] data_r;
  logic signed [cqs_pkg::DATA_W-1:0] key_r;
  logic                              probe_r;
  logic                              match;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data_r <= right_data;
    end else if (ctrl.load) begin
      data_r <= load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
    end else begin
      probe_r <= probe_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (probe_in.valid) begin
      key_r <= probe_in.key;
    end
  end

  assign match = (data_r == key_r);

  assign data            = data_r;
  assign probe_out.valid = probe_r && ctrl.active && !match;
  assign probe_out.key   = key_r;
  assign stat.hit        = probe_r && ctrl.active && match;
  assign stat.miss       = probe_r && !ctrl.active;

endmodule

`default_nettype wire

// File: rtl/circular_queue_with_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Circular FIFO of DEPTH signed 32-bit words with a linear search. Each input
// beat carries an operation: enqueue stores in_value at the tail (status full
// when all DEPTH entries are taken), dequeue returns the head word (status
// empty when nothing is queued), search returns the physical slot of the
// oldest entry equal to in_value (status empty or not found otherwise).
// Every input beat yields exactly one result beat. Enqueue, dequeue and an
// unused operation code register their result in the cycle after the beat
// is accepted. A search reports a hit at the cell that holds the oldest
// match; a miss is reported when the probe reaches the first empty cell, or
// on a full queue when the probe falls off the tail end. The search probe
// walks down the cell row one cell per cycle. No new beat is taken while a
// search runs. A pending result may be taken in the same cycle a new beat is
// accepted.
module circular_queue_with_search #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [cqs_pkg::OP_W-1:0]            in_op,
  input  wire logic signed [cqs_pkg::DATA_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cqs_pkg::STATUS_W-1:0]             out_status,
  output logic signed [cqs_pkg::DATA_W-1:0]        out_data_out,
  output logic [cqs_pkg::SLOT_W-1:0]               out_slot
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t                             state_r, state_nxt;
  logic [IW-1:0]                      head_r, head_nxt;
  logic [CW-1:0]                      occ_r, occ_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [cqs_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [cqs_pkg::DATA_W-1:0]  out_data_r, out_data_nxt;
  logic [cqs_pkg::SLOT_W-1:0]         out_slot_r, out_slot_nxt;

  logic in_acc;
  logic out_acc;
  logic is_full;
  logic is_empty;
  logic enq_ok;
  logic deq_ok;
  logic launch;

  // cell row: index 0 is the head; dequeue shifts every word one cell down
  cqs_pkg::cell_ctrl_t                ctrl   [DEPTH];
  logic signed [cqs_pkg::DATA_W-1:0]  cdata  [DEPTH];
  cqs_pkg::probe_t                    probe  [DEPTH+1];
  cqs_pkg::cell_stat_t                cstat  [DEPTH];
  logic [DEPTH-1:0]                   hit_vec;
  logic [DEPTH-1:0]                   miss_vec;

  logic                               any_hit;
  logic                               any_miss;
  logic [IW-1:0]                      hit_idx;
  logic [CW-1:0]                      phys_sum;
  logic [IW-1:0]                      phys_slot;
  logic [IW+cqs_pkg::SLOT_W-1:0]      slot_ext;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign is_full  = (occ_r == DEPTH_C);
  assign is_empty = (occ_r == '0);
  assign enq_ok   = in_acc && (in_op == cqs_pkg::OP_ENQ) && !is_full;
  assign deq_ok   = in_acc && (in_op == cqs_pkg::OP_DEQ) && !is_empty;
  assign launch   = in_acc && (in_op == cqs_pkg::OP_SRCH) && !is_empty;

  // probe enters the head cell with the search key
  assign probe[0].valid = launch;
  assign probe[0].key   = in_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [cqs_pkg::DATA_W-1:0] right;

    assign ctrl[i].shift  = deq_ok;
    assign ctrl[i].load   = enq_ok && (occ_r == CW'(i));
    assign ctrl[i].active = (CW'(i) < occ_r);

    if (i == DEPTH - 1) begin : g_end
      assign right = cdata[i];
    end else begin : g_mid
      assign right = cdata[i+1];
    end

    cqs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl[i]),
      .load_data  (in_value),
      .right_data (right),
      .probe_in   (probe[i]),
      .data       (cdata[i]),
      .probe_out  (probe[i+1]),
      .stat       (cstat[i])
    );

    assign hit_vec[i]  = cstat[i].hit;
    assign miss_vec[i] = cstat[i].miss;
  end

  // a probe falling off the tail end means a full queue without a match
  assign any_hit  = |hit_vec;
  assign any_miss = (|miss_vec) || probe[DEPTH].valid;

  // only one cell can hold the probe, so an OR of indexes encodes the hit
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // queue position -> physical slot: head plus position, modulo DEPTH
  always_comb begin
    phys_sum = {1'b0, head_r} + {1'b0, hit_idx};
    if (phys_sum >= DEPTH_C) begin
      phys_sum = phys_sum - DEPTH_C;
    end
    phys_slot = phys_sum[IW-1:0];
    slot_ext  = {{cqs_pkg::SLOT_W{1'b0}}, phys_slot};
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_acc ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_slot_nxt   = out_slot_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_status_nxt = cqs_pkg::ST_OK;
          out_data_nxt   = '0;
          out_slot_nxt   = '0;
          out_valid_nxt  = 1'b1;
          case (in_op)
            cqs_pkg::OP_ENQ: begin
              if (is_full) begin
                out_status_nxt = cqs_pkg::ST_FULL;
              end else begin
                occ_nxt = occ_r + CW'(1);
              end
            end
            cqs_pkg::OP_DEQ: begin
              if (is_empty) begin
                out_status_nxt = cqs_pkg::ST_EMPTY;
              end else begin
                out_data_nxt = cdata[0];
                head_nxt     = (head_r == LAST_SLOT) ? '0 : head_r + IW'(1);
                occ_nxt      = occ_r - CW'(1);
              end
            end
            cqs_pkg::OP_SRCH: begin
              if (is_empty) begin
                out_status_nxt = cqs_pkg::ST_EMPTY;
              end else begin
                // result comes when the probe settles
                out_valid_nxt = 1'b0;
                state_nxt     = S_SEARCH;
              end
            end
            default: begin
              // unused code: plain ok beat, state untouched
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (any_hit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cqs_pkg::ST_OK;
          out_data_nxt   = '0;
          out_slot_nxt   = slot_ext[cqs_pkg::SLOT_W-1:0];
          state_nxt      = S_IDLE;
        end else if (any_miss) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = cqs_pkg::ST_NOTFOUND;
          out_data_nxt   = '0;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      occ_r        <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= cqs_pkg::ST_OK;
      out_data_r   <= '0;
      out_slot_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      occ_r        <= occ_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_slot     = out_slot_r;

  // occupancy never runs past the row length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("occupancy above depth");

  // a running search owns the result register
  a_search_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> !out_valid_r)
    else $error("result pending during search");

  // at most one cell reports a search outcome
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec | miss_vec))
    else $error("more than one probe in cell row");

  // a search outcome only shows while searching
  a_probe_state: assert property (@(posedge clk) disable iff (!rst_n)
    (any_hit || any_miss) |-> (state_r == S_SEARCH))
    else $error("probe outside search");

  // a successful dequeue drops occupancy by one
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    deq_ok |=> (occ_r == $past(occ_r) - CW'(1)))
    else $error("dequeue count slip");

endmodule

`default_nettype wire

// File: tb/cqs_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the queue, keeps its own copy of the queue state,
// predicts one result per accepted op beat and compares out beats in order.
module cqs_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire logic                              in_ready,
  input  wire logic [cqs_pkg::OP_W-1:0]          in_op,
  input  wire logic signed [cqs_pkg::DATA_W-1:0] in_value,
  input  wire logic                              out_valid,
  input  wire logic                              out_ready,
  input  wire logic [cqs_pkg::STATUS_W-1:0]      out_status,
  input  wire logic signed [cqs_pkg::DATA_W-1:0] out_data_out,
  input  wire logic [cqs_pkg::SLOT_W-1:0]        out_slot,
  output int                                     fail_count,
  output int                                     pending
);

  typedef struct packed {
    logic [cqs_pkg::STATUS_W-1:0] status;
    logic [cqs_pkg::DATA_W-1:0]   data_out;
    logic [cqs_pkg::SLOT_W-1:0]   slot;
  } queue_result_t;

  logic [cqs_pkg::DATA_W-1:0] words [DEPTH];
  int unsigned head_idx, tail_idx, fill;
  queue_result_t expected_results [$];
  int mismatches = 0;
  int outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what,
                                 input logic [cqs_pkg::DATA_W-1:0] got,
                                 input logic [cqs_pkg::DATA_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // one op against the shadow queue; returns the result it should give
  function automatic queue_result_t apply_op(input logic [cqs_pkg::OP_W-1:0] op,
                                             input logic [cqs_pkg::DATA_W-1:0] key);
    queue_result_t r;
    int unsigned s;
    bit hit;
    r = '0;
    hit = 1'b0;
    case (op)
      cqs_pkg::OP_ENQ: begin
        if (fill >= DEPTH) begin
          r.status = cqs_pkg::ST_FULL;
        end else begin
          words[tail_idx] = key;
          tail_idx = (tail_idx + 1) % DEPTH;
          fill++;
        end
      end
      cqs_pkg::OP_DEQ: begin
        if (fill == 0) begin
          r.status = cqs_pkg::ST_EMPTY;
        end else begin
          r.data_out = words[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          fill--;
        end
      end
      cqs_pkg::OP_SRCH: begin
        if (fill == 0) begin
          r.status = cqs_pkg::ST_EMPTY;
        end else begin
          s = head_idx;
          for (int i = 0; i < fill && !hit; i++) begin
            if (words[s] == key) hit = 1'b1;
            else s = (s + 1) % DEPTH;
          end
          if (hit) r.slot = s[cqs_pkg::SLOT_W-1:0];
          else r.status = cqs_pkg::ST_NOTFOUND;
        end
      end
      default: ;  // unused code: ignored, plain ok
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    queue_result_t want;
    if (!rst_n) begin
      head_idx = 0;
      tail_idx = 0;
      fill = 0;
      foreach (words[i]) words[i] = '0;
      expected_results.delete();
    end else begin
      // push first: a result taken while its own op beat is accepted would still find its own entry
      if (in_valid && in_ready)
        expected_results.push_back(apply_op(in_op, in_value));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", out_status, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_data_out !== want.data_out)
            report_mismatch("data_out", out_data_out, want.data_out);
          if (out_slot !== want.slot)
            report_mismatch("slot", out_slot, want.slot);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

// Top of the queue testbench: clock, the single reset, op stimulus and the
// out_ready pattern. All prediction and comparison live in cqs_checker.
module testbench;

  localparam int unsigned DEPTH = 8;
  localparam int LIMIT = 400000;           // cycles; slowest legal run is far below
  localparam int PHASE_ITEMS = 460;        // four idling phases
  localparam int HOLD_CYCLES = 150;        // long receiver hold-off
  localparam logic [cqs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [cqs_pkg::OP_W-1:0] in_op = cqs_pkg::OP_ENQ;
  logic signed [cqs_pkg::DATA_W-1:0] in_value = '0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic [cqs_pkg::STATUS_W-1:0] out_status;
  logic signed [cqs_pkg::DATA_W-1:0] out_data_out;
  logic [cqs_pkg::SLOT_W-1:0] out_slot;

  int fail_count, pending;
  int cycles = 0;

  // idling knobs, percent of cycles
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  // long hold requests are counted here and served by the receiver process
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  // recently enqueued words, so searches mostly hit
  logic [cqs_pkg::DATA_W-1:0] recent [16] = '{default: '0};
  int unsigned recent_wr = 0;

  always #4 clk = ~clk;

  circular_queue_with_search #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_slot     (out_slot)
  );

  cqs_checker #(.DEPTH(DEPTH)) result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out),
    .out_slot     (out_slot),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // out_ready: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Called at a falling edge. An optional gap drops in_valid first; the next
  // beat then goes out on a later falling edge, so in_valid is never lowered
  // and raised in one step. Returns at the falling edge after the handshake.
  task automatic send_beat(input logic [cqs_pkg::OP_W-1:0] op,
                           input logic [cqs_pkg::DATA_W-1:0] v);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (op == cqs_pkg::OP_ENQ) begin
      recent[recent_wr % 16] = v;
      recent_wr++;
    end
  endtask

  // sender pauses until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [cqs_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom_range(7);                // small values give duplicates
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // enq_bias: percent of enqueue among enqueue/dequeue, swept per segment so
  // the queue keeps running between empty and full
  task automatic random_beat(input int unsigned enq_bias);
    logic [cqs_pkg::OP_W-1:0] op;
    logic [cqs_pkg::DATA_W-1:0] v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) op = OP_UNUSED;
    else if (r < 33) op = cqs_pkg::OP_SRCH;
    else if ($urandom_range(99) < enq_bias) op = cqs_pkg::OP_ENQ;
    else op = cqs_pkg::OP_DEQ;
    if (op == cqs_pkg::OP_SRCH && $urandom_range(99) < 60) v = recent[$urandom_range(15)];
    else v = pick_word();
    send_beat(op, v);
  endtask

  initial begin
    int unsigned bias;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty cases, extremes, fill to full, duplicates, wrap
    send_beat(cqs_pkg::OP_SRCH, 32'd5);              // search on empty
    send_beat(cqs_pkg::OP_DEQ, '0);                  // dequeue on empty
    send_beat(OP_UNUSED, 32'hdead_beef);             // unused code is ignored
    send_beat(cqs_pkg::OP_ENQ, 32'h8000_0000);
    send_beat(cqs_pkg::OP_ENQ, 32'h7fff_ffff);
    send_beat(cqs_pkg::OP_ENQ, '0);
    send_beat(cqs_pkg::OP_ENQ, '1);
    send_beat(cqs_pkg::OP_SRCH, '1);                 // hit at the newest entry
    send_beat(cqs_pkg::OP_SRCH, 32'h8000_0000);      // hit at head
    send_beat(cqs_pkg::OP_SRCH, 32'd12345);          // no match
    send_beat(cqs_pkg::OP_ENQ, 32'd7);
    send_beat(cqs_pkg::OP_ENQ, 32'd7);
    send_beat(cqs_pkg::OP_ENQ, 32'd9);
    send_beat(cqs_pkg::OP_ENQ, 32'd10);              // now full
    send_beat(cqs_pkg::OP_ENQ, 32'd11);              // enqueue on full
    send_beat(cqs_pkg::OP_SRCH, 32'd10);             // hit at tail end, full scan
    send_beat(cqs_pkg::OP_SRCH, 32'd7);              // first of two equal entries
    send_beat(cqs_pkg::OP_DEQ, '0);
    send_beat(cqs_pkg::OP_DEQ, '0);
    send_beat(cqs_pkg::OP_DEQ, '0);
    send_beat(cqs_pkg::OP_ENQ, 32'd11);              // tail wraps to slot 0
    send_beat(cqs_pkg::OP_ENQ, 32'd13);
    send_beat(cqs_pkg::OP_SRCH, 32'd13);             // match past the wrap
    send_beat(cqs_pkg::OP_SRCH, 32'd0);              // searched word gone
    drain_results();

    bias = 50;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 16; rcv_stall_pct = 16; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: bias = 15;
            1: bias = 50;
            default: bias = 85;
          endcase
        end
        // back pressure: long hold while beats keep coming, later a full drain
        if (phase == 0 && n == 120) hold_requests++;
        if (phase == 0 && n == 300) drain_results();
        random_beat(bias);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
